// File: sv/dqn_pkg.sv
// Shared types, constants and helper functions for the DNS query name extractor.
package dqn_pkg;

	// Frame byte counter: saturates at MAX_FRAME_BYTES, so it must hold that value.
	localparam int MAX_FRAME_BYTES = 2048;
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

	// Result queue between parser and output side (depth must be a power of two).
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Protocol constants
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
	localparam logic [15:0] DNS_PORT_RESET = 16'd53;
	localparam logic [7:0]  DNS_QR_MASK    = 8'h80;  // QR is bit 15 of the flags word
	localparam logic [7:0]  ZERO_LABEL     = 8'h00;
	localparam logic [7:0]  DOT_CHAR       = 8'h2E;

	// Fixed byte offsets inside the headers
	localparam int ETH_TYPE_LO   = 13;
	localparam int IP_START      = 14;
	localparam int IP_PROTO_OFS  = 9;
	localparam int IP_SRC_FIRST  = 12;
	localparam int IP_SRC_LAST   = 15;
	localparam int IP_DST_FIRST  = 16;
	localparam int IP_DST_LAST   = 19;
	localparam int IHL_MIN       = 5;
	localparam int UDP_SPORT_LO  = 1;
	localparam int UDP_DPORT_LO  = 3;
	localparam int UDP_LAST      = 7;
	localparam int UDP_LEN       = 8;
	localparam int DNS_FLAGS_HI  = 2;
	localparam int DNS_HDR_LAST  = 11;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} frame_t;

	typedef struct packed {
		logic [7:0]  name_char;
		logic        name_done;
		logic        truncated;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [15:0] source_port;
		logic [15:0] dest_port;
	} result_t;

	// Up to two result words written into the queue per accepted byte
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_bus_t;

	typedef enum logic [5:0] {
		PH_ETH  = 6'b000001,
		PH_IP   = 6'b000010,
		PH_UDP  = 6'b000100,
		PH_DNSH = 6'b001000,
		PH_NAME = 6'b010000,
		PH_SKIP = 6'b100000
	} phase_t;

	function automatic result_t char_word(input logic [7:0] ch);
		result_t r;
		r           = '0;
		r.name_char = ch;
		return r;
	endfunction

	function automatic result_t end_word(input logic trunc, input logic [31:0] sip,
		input logic [31:0] dip, input logic [15:0] sport, input logic [15:0] dport);
		result_t r;
		r.name_char   = 8'h00;
		r.name_done   = 1'b1;
		r.truncated   = trunc;
		r.source_ip   = sip;
		r.dest_ip     = dip;
		r.source_port = sport;
		r.dest_port   = dport;
		return r;
	endfunction

endpackage

// File: sv/dqn_parser.sv
// Front end: header classification and query name decoding, one byte per cycle while accept is high.
module dqn_parser import dqn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_t      frame,
	input  logic        accept,
	input  logic [15:0] dns_port,
	output push_bus_t   bus
);

	logic [POS_W-1:0] pos_q, pos_nx;
	phase_t           phase_q, phase_nx;
	logic [3:0]       hw_q, hw_nx;
	logic [31:0]      sip_q, sip_nx, dip_q, dip_nx;
	logic [15:0]      sport_q, sport_nx, dport_q, dport_nx;
	logic [7:0]       rem_q, rem_nx;
	logic             first_q, first_nx;
	logic [7:0]       prev_q, prev_nx;

	logic [7:0]       b;
	logic [POS_W-1:0] udp0, rel_ip, rel_udp, rel_dns, ip_last;
	result_t          r0, r1;
	logic [1:0]       n;

	assign b       = frame.frame_byte;
	assign udp0    = POS_W'(IP_START) + POS_W'({hw_q, 2'b00});
	assign ip_last = POS_W'({hw_q, 2'b00}) - POS_W'(1);
	assign rel_ip  = pos_q - POS_W'(IP_START);
	assign rel_udp = pos_q - udp0;
	assign rel_dns = pos_q - udp0 - POS_W'(UDP_LEN);

	// Next state and results for the byte on the input
	always_comb begin
		pos_nx   = pos_q;
		phase_nx = phase_q;
		hw_nx    = hw_q;
		sip_nx   = sip_q;
		dip_nx   = dip_q;
		sport_nx = sport_q;
		dport_nx = dport_q;
		rem_nx   = rem_q;
		first_nx = first_q;
		prev_nx  = prev_q;
		r0       = '0;
		r1       = '0;
		n        = 2'd0;

		if (pos_q < POS_W'(MAX_FRAME_BYTES)) begin
			case (phase_q)
				PH_ETH: begin
					if (pos_q == POS_W'(ETH_TYPE_LO))
						phase_nx = ({prev_q, b} == ETHERTYPE_IPV4) ? PH_IP : PH_SKIP;
				end
				PH_IP: begin
					if (rel_ip == '0) begin
						hw_nx = b[3:0];
						if (b[3:0] < 4'(IHL_MIN)) phase_nx = PH_SKIP;
					end else if (rel_ip == POS_W'(IP_PROTO_OFS) && b != IP_PROTO_UDP) begin
						phase_nx = PH_SKIP;
					end else begin
						if (rel_ip >= POS_W'(IP_SRC_FIRST) && rel_ip <= POS_W'(IP_SRC_LAST))
							sip_nx = {sip_q[23:0], b};
						if (rel_ip >= POS_W'(IP_DST_FIRST) && rel_ip <= POS_W'(IP_DST_LAST))
							dip_nx = {dip_q[23:0], b};
						if (rel_ip == ip_last) phase_nx = PH_UDP;
					end
				end
				PH_UDP: begin
					if (rel_udp <= POS_W'(UDP_SPORT_LO))
						sport_nx = {sport_q[7:0], b};
					else if (rel_udp <= POS_W'(UDP_DPORT_LO))
						dport_nx = {dport_q[7:0], b};
					if (rel_udp == POS_W'(UDP_DPORT_LO) && {dport_q[7:0], b} != dns_port)
						phase_nx = PH_SKIP;
					else if (rel_udp == POS_W'(UDP_LAST))
						phase_nx = PH_DNSH;
				end
				PH_DNSH: begin
					if (rel_dns == POS_W'(DNS_FLAGS_HI) && (b & DNS_QR_MASK) != 8'h00)
						phase_nx = PH_SKIP;
					else if (rel_dns == POS_W'(DNS_HDR_LAST))
						phase_nx = PH_NAME;
				end
				PH_NAME: begin
					if (rem_q == 8'd0) begin
						if (b == ZERO_LABEL) begin
							r0       = end_word(1'b0, sip_q, dip_q, sport_q, dport_q);
							n        = 2'd1;
							phase_nx = PH_SKIP;
						end else begin
							if (!first_q) begin
								r0 = char_word(DOT_CHAR);
								n  = 2'd1;
							end
							first_nx = 1'b0;
							rem_nx   = b;
						end
					end else begin
						r0     = char_word(b);
						n      = 2'd1;
						rem_nx = rem_q - 8'd1;
					end
				end
				default: ;
			endcase
			pos_nx  = pos_q + POS_W'(1);
			prev_nx = b;
		end

		// Frame end: close an open name, then restart for the next frame
		if (frame.frame_end) begin
			if (phase_nx == PH_NAME) begin
				if (n == 2'd0) r0 = end_word(1'b1, sip_q, dip_q, sport_q, dport_q);
				else           r1 = end_word(1'b1, sip_q, dip_q, sport_q, dport_q);
				n = n + 2'd1;
			end
			pos_nx   = '0;
			phase_nx = PH_ETH;
			hw_nx    = '0;
			sip_nx   = '0;
			dip_nx   = '0;
			sport_nx = '0;
			dport_nx = '0;
			rem_nx   = '0;
			first_nx = 1'b1;
			prev_nx  = '0;
		end
	end

	assign bus.count = accept ? n : 2'd0;
	assign bus.r0    = r0;
	assign bus.r1    = r1;

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_ETH;
			hw_q    <= '0;
			sip_q   <= '0;
			dip_q   <= '0;
			sport_q <= '0;
			dport_q <= '0;
			rem_q   <= '0;
			first_q <= 1'b1;
			prev_q  <= '0;
		end else if (accept) begin
			pos_q   <= pos_nx;
			phase_q <= phase_nx;
			hw_q    <= hw_nx;
			sip_q   <= sip_nx;
			dip_q   <= dip_nx;
			sport_q <= sport_nx;
			dport_q <= dport_nx;
			rem_q   <= rem_nx;
			first_q <= first_nx;
			prev_q  <= prev_nx;
		end
	end

endmodule

// File: sv/dqn_queue.sv
// Back end: result queue taking up to two words per cycle and giving one per pop.
module dqn_queue import dqn_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  push_bus_t wr,
	input  logic      pop,
	output logic      full,
	output logic      empty,
	output result_t   head
);

	result_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop_ok;

	assign empty  = (cnt_q == '0);
	// Room for two words must remain, since one byte can give two results
	assign full   = (cnt_q > QCNT_W'(QDEPTH - 2));
	assign pop_ok = pop && !empty;
	assign head   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr.count != 2'd0) mem_q[wr_ptr_q] <= wr.r0;
		if (wr.count == 2'd2) mem_q[wr_ptr_q + QPTR_W'(1)] <= wr.r1;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(wr.count);
			if (pop_ok) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(wr.count) - QCNT_W'(pop_ok);
		end
	end

endmodule

// File: sv/dns_query_name_extractor.sv
// Top level of the DNS query name extractor: config register, parser and result queue.
//
// Frame bytes enter through a queue-style port: a word is taken on a rising
// edge with push high and full low, frame_end marking the last byte.
// Results leave the same way: the oldest word sits on result while empty is
// low and is taken on an edge with pop high. Each name character (and each
// dot between labels) is one word; a closing word with name_done set carries
// the addresses and ports, with truncated set if the frame ended in the name.
// The dns_port register is written over cfg_valid/cfg_ready; ready is always
// high and writes belong between frames.
// Throughput: one byte per cycle while full is low, set by the parser's single state update.
// A result is written into the queue on the edge that takes its byte and reaches result once older words are popped.
// The result queue holds four words; full rises once fewer than two are free,
// so a stalled receiver backs up into the byte side.
// Reset clears the parser to the Ethernet header, empties the queue and
// loads dns_port with 53.
module dns_query_name_extractor import dqn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_t      frame,
	input  logic        push,
	output logic        full,
	output result_t     result,
	output logic        empty,
	input  logic        pop,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [15:0] dns_port_q;
	logic        accept;
	push_bus_t   bus;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dns_port_q <= DNS_PORT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dns_port_q <= cfg_data;
		end
	end

	dqn_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.accept   (accept),
		.dns_port (dns_port_q),
		.bus      (bus)
	);

	dqn_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (bus),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (result)
	);

endmodule

// File: sv/dqn_checker.sv
// Port-level checks for the DNS query name extractor, bound to the top level.
module dqn_checker import dqn_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    push,
	input logic    full,
	input logic    pop,
	input logic    empty,
	input result_t result
);

	// No result can appear without a byte going in
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !(push && !full)) |=> empty)
		else $error("result appeared with no byte accepted");

	// Character words carry no end information
	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.name_done) |-> (!result.truncated && result.source_ip == '0
		&& result.dest_ip == '0 && result.source_port == '0 && result.dest_port == '0))
		else $error("character word carries end fields");

	// The end word has a zero character
	a_end_char: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.name_done) |-> (result.name_char == 8'h00))
		else $error("end word with nonzero character");

	// A waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed");

endmodule

bind dns_query_name_extractor dqn_checker u_dqn_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.pop    (pop),
	.empty  (empty),
	.result (result)
);

// File: bench/dqn_name_monitor.sv
`timescale 1ns / 100ps
// Monitor for the DNS name extractor: predicts every result word from the accepted bytes and compares.
module dqn_name_monitor import dqn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_t      frame,
	input  logic        push,
	input  logic        full,
	input  result_t     result,
	input  logic        empty,
	input  logic        pop,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          outstanding
);

	// Expected result words, oldest first
	result_t     want_q[$];

	// Predicted parser state
	logic [15:0] port_cfg;
	phase_t      parse_ph;
	int          byte_pos;
	logic [3:0]  ihl_words;
	logic [31:0] src_ip;
	logic [31:0] dst_ip;
	logic [15:0] udp_sport;
	logic [15:0] udp_dport;
	logic [7:0]  label_left;
	logic        first_lbl;
	logic [7:0]  last_byte;

	task automatic flag(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors = errors + 1;
	endtask

	task automatic cmp_field(input string nm, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			flag($sformatf("%s: got %0h, want %0h", nm, got, want));
	endtask

	task automatic restart_frame();
		byte_pos   = 0;
		parse_ph   = PH_ETH;
		ihl_words  = '0;
		src_ip     = '0;
		dst_ip     = '0;
		udp_sport  = '0;
		udp_dport  = '0;
		label_left = '0;
		first_lbl  = 1'b1;
		last_byte  = '0;
	endtask

	task automatic want_char(input logic [7:0] ch);
		result_t r;
		r           = '0;
		r.name_char = ch;
		want_q.push_back(r);
	endtask

	task automatic want_end(input logic trunc);
		result_t r;
		r.name_char   = 8'h00;
		r.name_done   = 1'b1;
		r.truncated   = trunc;
		r.source_ip   = src_ip;
		r.dest_ip     = dst_ip;
		r.source_port = udp_sport;
		r.dest_port   = udp_dport;
		want_q.push_back(r);
	endtask

	// One frame byte through the header walk and the label decoder
	task automatic parse(input logic [7:0] b);
		int rel;
		int udp0;
		udp0 = IP_START + 4 * int'(ihl_words);
		case (parse_ph)
		PH_ETH: begin
			if (byte_pos == ETH_TYPE_LO)
				parse_ph = ({last_byte, b} == ETHERTYPE_IPV4) ? PH_IP : PH_SKIP;
		end
		PH_IP: begin
			rel = byte_pos - IP_START;
			if (rel == 0) begin
				ihl_words = b[3:0];
				if (int'(ihl_words) < IHL_MIN)
					parse_ph = PH_SKIP;
			end else if (rel == IP_PROTO_OFS && b != IP_PROTO_UDP) begin
				parse_ph = PH_SKIP;
			end else begin
				if (rel >= IP_SRC_FIRST && rel <= IP_SRC_LAST)
					src_ip = {src_ip[23:0], b};
				if (rel >= IP_DST_FIRST && rel <= IP_DST_LAST)
					dst_ip = {dst_ip[23:0], b};
				if (rel == 4 * int'(ihl_words) - 1)
					parse_ph = PH_UDP;
			end
		end
		PH_UDP: begin
			rel = byte_pos - udp0;
			if (rel <= UDP_SPORT_LO)
				udp_sport = {udp_sport[7:0], b};
			else if (rel <= UDP_DPORT_LO)
				udp_dport = {udp_dport[7:0], b};
			if (rel == UDP_DPORT_LO && udp_dport != port_cfg)
				parse_ph = PH_SKIP;
			else if (rel == UDP_LAST)
				parse_ph = PH_DNSH;
		end
		PH_DNSH: begin
			rel = byte_pos - (udp0 + UDP_LEN);
			if (rel == DNS_FLAGS_HI && (b & DNS_QR_MASK) != 8'h00)
				parse_ph = PH_SKIP;
			else if (rel == DNS_HDR_LAST)
				parse_ph = PH_NAME;
		end
		PH_NAME: begin
			if (label_left == 8'h00) begin
				if (b == ZERO_LABEL) begin
					want_end(1'b0);
					parse_ph = PH_SKIP;
				end else begin
					if (!first_lbl)
						want_char(DOT_CHAR);
					first_lbl  = 1'b0;
					label_left = b;
				end
			end else begin
				want_char(b);
				label_left = label_left - 8'd1;
			end
		end
		default: ;
		endcase
		last_byte = b;
	endtask

	// Accepted byte: parse within the byte limit, close the frame on its last byte
	task automatic take_byte(input frame_t f);
		if (byte_pos < MAX_FRAME_BYTES) begin
			parse(f.frame_byte);
			byte_pos++;
		end
		if (f.frame_end) begin
			if (parse_ph == PH_NAME)
				want_end(1'b1);
			restart_frame();
		end
	endtask

	task automatic check_word();
		result_t w;
		if (want_q.size() == 0) begin
			flag($sformatf("result word %h with none expected", result));
			return;
		end
		w = want_q.pop_front();
		cmp_field("name_char", 32'(result.name_char), 32'(w.name_char));
		cmp_field("name_done", 32'(result.name_done), 32'(w.name_done));
		cmp_field("truncated", 32'(result.truncated), 32'(w.truncated));
		cmp_field("source_ip", result.source_ip, w.source_ip);
		cmp_field("dest_ip", result.dest_ip, w.dest_ip);
		cmp_field("source_port", 32'(result.source_port), 32'(w.source_port));
		cmp_field("dest_port", 32'(result.dest_port), 32'(w.dest_port));
	endtask

	// Sample all channels at the clock edge; a byte sees the port value from before the edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_q.delete();
			port_cfg = DNS_PORT_RESET;
			restart_frame();
			outstanding <= 0;
		end else begin
			if (pop && !empty)
				check_word();
			if (push && !full)
				take_byte(frame);
			if (cfg_valid && cfg_ready)
				port_cfg = cfg_data;
			outstanding <= want_q.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Testbench top for the DNS name extractor: clock, reset, frame stimulus, port writes and verdict.
module tb;
	import dqn_pkg::*;

	localparam int RAND_ITEMS    = 360;
	localparam int NUM_PHASES    = 4;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 1000000;

	typedef enum int {
		K_GOOD, K_CUT, K_ETYPE, K_PROTO, K_PORT, K_QR, K_IHL, K_NOISE, K_LONG, K_PAD
	} frame_kind_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	frame_t      frame     = '0;
	logic        push      = 1'b0;
	logic        full;
	result_t     result;
	logic        empty;
	logic        pop       = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = '0;

	int          errors;
	int          outstanding;
	int          send_idle   = 0;
	int          stall_pct   = 0;
	int          phase_bytes = 0;
	int          cycle_count = 0;
	logic [15:0] cur_port;
	logic [7:0]  fbuf[$];

	dns_query_name_extractor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame),
		.push      (push),
		.full      (full),
		.result    (result),
		.empty     (empty),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	dqn_name_monitor mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame       (frame),
		.push        (push),
		.full        (full),
		.result      (result),
		.empty       (empty),
		.pop         (pop),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: random pop per cycle
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= stall_pct);
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dns_query_name_extractor: mismatch");
			$finish;
		end
	end

	// One byte word; returns on the accepting edge, then maybe idles
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		frame <= '{frame_byte: b, frame_end: last};
		push  <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		gap = 0;
		while ($urandom_range(99) < send_idle) gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put_bytes(input logic [31:0] v, input int n);
		int i;
		for (i = n - 1; i >= 0; i--) fbuf.push_back(v[8*i +: 8]);
	endtask

	// Build one frame of the given kind and send it; -1 means random for each knob.
	// cut_set counts the name bytes kept by a cut frame.
	task automatic send_query(input frame_kind_t kind, input int ihl_set, input int nlab_set,
		input int lablen_set, input int tail_set, input int cut_set);
		int ihl, nlab, lablen, n0, zidx, keep, i;
		logic [15:0] etype, dp;
		logic [7:0]  proto;
		logic        qr;
		fbuf.delete();
		etype = ETHERTYPE_IPV4;
		proto = IP_PROTO_UDP;
		dp    = cur_port;
		qr    = 1'b0;
		ihl   = (ihl_set >= 0) ? ihl_set :
			(($urandom_range(3) == 0) ? $urandom_range(IHL_MIN + 1, 15) : IHL_MIN);
		case (kind)
		K_ETYPE: etype = etype ^ (16'h1 << $urandom_range(15));
		K_PROTO: proto = IP_PROTO_UDP ^ 8'($urandom_range(1, 255));
		K_PORT:  dp = dp ^ (16'h1 << $urandom_range(15));
		K_QR:    qr = 1'b1;
		K_IHL: begin
			if (ihl_set < 0)
				ihl = $urandom_range(IHL_MIN - 1);
		end
		default: ;
		endcase
		if (kind == K_NOISE) begin
			repeat ($urandom_range(1, 60)) fbuf.push_back(8'($urandom));
		end else begin
			// Ethernet addresses and type
			repeat (12) fbuf.push_back(8'($urandom));
			put_bytes(32'(etype), 2);
			// IPv4 header, any version nibble
			fbuf.push_back({4'($urandom), 4'(ihl)});
			for (i = 1; i < ((ihl < IHL_MIN) ? 20 : 4 * ihl); i++)
				fbuf.push_back((i == IP_PROTO_OFS) ? proto : 8'($urandom));
			// UDP header
			put_bytes($urandom, 2);
			put_bytes(32'(dp), 2);
			put_bytes($urandom, 4);
			// DNS header, QR in the top bit of the flags word
			for (i = 0; i < 12; i++)
				fbuf.push_back((i == DNS_FLAGS_HI) ? {qr, 7'($urandom)} : 8'($urandom));
			n0 = fbuf.size();
			if (kind == K_LONG) begin
				// name runs past the byte limit with no zero label
				while (fbuf.size() < MAX_FRAME_BYTES + 40) begin
					fbuf.push_back(8'hFF);
					repeat (255) fbuf.push_back(8'($urandom));
				end
			end else begin
				nlab = (nlab_set >= 0) ? nlab_set : $urandom_range(1, 4);
				for (i = 0; i < nlab; i++) begin
					lablen = (lablen_set > 0) ? lablen_set :
						(($urandom_range(15) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8));
					fbuf.push_back(8'(lablen));
					repeat (lablen) fbuf.push_back(8'($urandom));
				end
				zidx = fbuf.size();
				fbuf.push_back(ZERO_LABEL);
				repeat ((tail_set >= 0) ? tail_set : $urandom_range(6))
					fbuf.push_back(8'($urandom));
				if (kind == K_PAD)
					while (fbuf.size() < MAX_FRAME_BYTES + 40) fbuf.push_back(8'($urandom));
				if (kind == K_CUT) begin
					if (cut_set >= 0)
						keep = n0 + cut_set;
					else if ($urandom_range(1))
						keep = $urandom_range(n0 + 1, zidx);
					else
						keep = $urandom_range(1, n0);
					while (fbuf.size() > keep) fbuf.pop_back();
				end
			end
		end
		for (i = 0; i < fbuf.size(); i++)
			send_byte(fbuf[i], i == fbuf.size() - 1);
		phase_bytes += fbuf.size();
	endtask

	function automatic frame_kind_t pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 60) return K_GOOD;
		if (r < 72) return K_CUT;
		if (r < 76) return K_ETYPE;
		if (r < 80) return K_PROTO;
		if (r < 85) return K_PORT;
		if (r < 89) return K_QR;
		if (r < 93) return K_IHL;
		return K_NOISE;
	endfunction

	// Wait out every expected word, then let the design settle with push low
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_port(input logic [15:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_port = v;
	endtask

	initial begin
		int ph_i;
		logic [15:0] port_v;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cur_port = DNS_PORT_RESET;

		// Directed frames at the reset port
		send_query(K_GOOD, IHL_MIN, 0, -1, -1, -1);     // empty name
		send_query(K_GOOD, 15, 4, 1, 0, -1);            // one-char labels, ends on zero label
		send_query(K_GOOD, IHL_MIN, 1, 64, -1, -1);     // length byte 64 taken literally
		send_query(K_CUT, -1, 2, 3, -1, 5);             // ends on a later length byte: dot, then end
		settle();

		// Random phases, each with its own port and idle pattern
		for (ph_i = 0; ph_i < NUM_PHASES; ph_i++) begin
			case (ph_i)
			0: begin
				port_v    = 16'h0000;
				send_idle = 0;
				stall_pct = 0;
			end
			1: begin
				port_v    = 16'hFFFF;
				send_idle = 84;
				stall_pct = 0;
			end
			2: begin
				port_v    = 16'($urandom);
				send_idle = 0;
				stall_pct = 84;
			end
			default: begin
				port_v    = DNS_PORT_RESET;
				send_idle = 19;
				stall_pct = 19;
			end
			endcase
			write_port(port_v);
			phase_bytes = 0;
			while (phase_bytes < RAND_ITEMS / NUM_PHASES)
				send_query(pick_kind(), -1, -1, -1, -1, -1);
			settle();
		end

		if (errors == 0)
			$display("dns_query_name_extractor: match");
		else
			$display("dns_query_name_extractor: mismatch");
		$finish;
	end

endmodule
